[rtl/xsar_pkg.sv]
// ----------------------------------------------------------------------------
// xsar_pkg
// Shared constants and types for the touch coordinate ASCII reporter.
// ----------------------------------------------------------------------------
`default_nettype none

package xsar_pkg;

  localparam int unsigned SAMPLE_W        = 10;
  localparam int unsigned LIMIT_W         = 11;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd900;
  localparam int unsigned DIGIT_COUNT_DEF = 5;

  // reciprocal multipliers for division by 100 and by 10
  localparam int unsigned DIV100_MUL   = 41;
  localparam int unsigned DIV100_SHIFT = 12;
  localparam int unsigned DIV10_MUL    = 205;
  localparam int unsigned DIV10_SHIFT  = 11;

  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef struct packed {
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] y;
  } sample_pair_t;

endpackage

`default_nettype wire

[rtl/xsar_front.sv]
// ----------------------------------------------------------------------------
// xsar_front
// Limit register, threshold check and input capture stage.
// ----------------------------------------------------------------------------
`default_nettype none

module xsar_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire xsar_pkg::sample_pair_t        sample_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [xsar_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  output logic                               out_valid_o,
  output xsar_pkg::sample_pair_t             out_pair_o,
  input  wire logic                          out_ready_i
);

  logic [xsar_pkg::LIMIT_W-1:0] limit_q;
  logic                         s1_v_q;
  logic                         s1_v_d;
  xsar_pkg::sample_pair_t       s1_pair_q;
  logic                         take;
  logic                         pass;
  logic                         s1_ready;

  assign s1_ready = !s1_v_q || out_ready_i;
  assign busy_o   = !s1_ready;
  assign take     = start_i && s1_ready;
  assign pass     = ({1'b0, sample_i.x} < limit_q) && ({1'b0, sample_i.y} < limit_q);

  // a pair that fails the limit is taken but leaves no valid item behind
  always_comb begin
    s1_v_d = s1_v_q;
    if (s1_ready) begin
      s1_v_d = take && pass;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= xsar_pkg::LIMIT_RESET;
      s1_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && pass) begin
      s1_pair_q <= sample_i;
    end
  end

  assign out_valid_o = s1_v_q;
  assign out_pair_o  = s1_pair_q;

endmodule

`default_nettype wire

[rtl/xsar_bcd.sv]
// ----------------------------------------------------------------------------
// xsar_bcd
// Two-stage binary to decimal digit split for both coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module xsar_bcd #(
  parameter int unsigned DIGIT_COUNT = xsar_pkg::DIGIT_COUNT_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire xsar_pkg::sample_pair_t in_pair_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [DIGIT_COUNT*4-1:0]    x_digits_o,
  output logic [DIGIT_COUNT*4-1:0]    y_digits_o,
  output logic                        x_zero_o,
  output logic                        y_zero_o
);

  // quotient by 100 (0..10) and remainder (0..99)
  function automatic logic [10:0] split_hund(input logic [9:0] v);
    logic [15:0] prod;
    logic [3:0]  h;
    logic [9:0]  r;
    prod = {6'b0, v} * 16'(xsar_pkg::DIV100_MUL);
    h    = 4'(prod >> xsar_pkg::DIV100_SHIFT);
    r    = v - ({6'b0, h} * 10'd100);
    if (r >= 10'd100) begin
      h = h + 4'd1;
      r = r - 10'd100;
    end
    return {h, r[6:0]};
  endfunction

  // four decimal digits, most significant first
  function automatic logic [15:0] split_low(input logic [3:0] h, input logic [6:0] r);
    logic [3:0]  th;
    logic [3:0]  hu;
    logic [14:0] prod;
    logic [3:0]  t;
    logic [6:0]  o;
    if (h >= 4'd10) begin
      th = 4'd1;
      hu = h - 4'd10;
    end else begin
      th = 4'd0;
      hu = h;
    end
    prod = {8'b0, r} * 15'(xsar_pkg::DIV10_MUL);
    t    = 4'(prod >> xsar_pkg::DIV10_SHIFT);
    o    = r - ({3'b0, t} * 7'd10);
    if (o >= 7'd10) begin
      t = t + 4'd1;
      o = o - 7'd10;
    end
    return {th, hu, t, o[3:0]};
  endfunction

  logic        s2_v_q;
  logic        s3_v_q;
  logic        s2_ready;
  logic        s3_ready;
  logic [10:0] s2_x_q;
  logic [10:0] s2_y_q;
  logic        s2_xz_q;
  logic        s2_yz_q;
  logic [15:0] s3_x_q;
  logic [15:0] s3_y_q;
  logic        s3_xz_q;
  logic        s3_yz_q;

  assign s3_ready   = !s3_v_q || out_ready_i;
  assign s2_ready   = !s2_v_q || s3_ready;
  assign in_ready_o = s2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_v_q <= in_valid_i;
      end
      if (s3_ready) begin
        s3_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && in_valid_i) begin
      s2_x_q  <= split_hund(in_pair_i.x);
      s2_y_q  <= split_hund(in_pair_i.y);
      s2_xz_q <= (in_pair_i.x == '0);
      s2_yz_q <= (in_pair_i.y == '0);
    end
    if (s3_ready && s2_v_q) begin
      s3_x_q  <= split_low(s2_x_q[10:7], s2_x_q[6:0]);
      s3_y_q  <= split_low(s2_y_q[10:7], s2_y_q[6:0]);
      s3_xz_q <= s2_xz_q;
      s3_yz_q <= s2_yz_q;
    end
  end

  // digits above the fourth are always zero for a 10-bit value
  for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_dig
    if (k < 4) begin : g_low
      assign x_digits_o[k*4 +: 4] = s3_x_q[k*4 +: 4];
      assign y_digits_o[k*4 +: 4] = s3_y_q[k*4 +: 4];
    end else begin : g_high
      assign x_digits_o[k*4 +: 4] = 4'd0;
      assign y_digits_o[k*4 +: 4] = 4'd0;
    end
  end

  assign out_valid_o = s3_v_q;
  assign x_zero_o    = s3_xz_q;
  assign y_zero_o    = s3_yz_q;

endmodule

`default_nettype wire

[rtl/xsar_serial.sv]
// ----------------------------------------------------------------------------
// xsar_serial
// Walks the report line template and sends one character per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module xsar_serial #(
  parameter int unsigned DIGIT_COUNT = xsar_pkg::DIGIT_COUNT_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [DIGIT_COUNT*4-1:0] x_digits_i,
  input  wire logic [DIGIT_COUNT*4-1:0] y_digits_i,
  input  wire logic                     x_zero_i,
  input  wire logic                     y_zero_i,
  output logic                          text_valid_o,
  output logic [7:0]                    text_byte_o,
  output logic                          line_end_o
);

  localparam int unsigned LINE_LEN = 2 * DIGIT_COUNT + 10;
  localparam int unsigned POS_W    = $clog2(LINE_LEN);
  localparam int unsigned IDX_W    = $clog2(DIGIT_COUNT);
  localparam int unsigned P_XNUM   = 4;
  localparam int unsigned P_XSP    = 4 + DIGIT_COUNT;
  localparam int unsigned P_Y      = 5 + DIGIT_COUNT;
  localparam int unsigned P_YC     = 6 + DIGIT_COUNT;
  localparam int unsigned P_YSP    = 7 + DIGIT_COUNT;
  localparam int unsigned P_YPLUS  = 8 + DIGIT_COUNT;
  localparam int unsigned P_YNUM   = 9 + DIGIT_COUNT;
  localparam int unsigned P_NL     = 9 + 2 * DIGIT_COUNT;

  logic                     v_q;
  logic [POS_W-1:0]         pos_q;
  logic [POS_W-1:0]         pos_d;
  logic [DIGIT_COUNT*4-1:0] xd_q;
  logic [DIGIT_COUNT*4-1:0] yd_q;
  logic                     xz_q;
  logic                     yz_q;
  logic                     last;
  logic                     load;
  logic [POS_W-1:0]         xoff;
  logic [POS_W-1:0]         yoff;
  logic [IDX_W-1:0]         xidx;
  logic [IDX_W-1:0]         yidx;
  logic [7:0]               xch;
  logic [7:0]               ych;

  assign last       = (pos_q == POS_W'(P_NL));
  assign in_ready_o = !v_q || last;
  assign load       = in_valid_i && in_ready_o;

  assign xoff = pos_q - POS_W'(P_XNUM);
  assign yoff = pos_q - POS_W'(P_YNUM);
  assign xidx = IDX_W'(DIGIT_COUNT - 1) - xoff[IDX_W-1:0];
  assign yidx = IDX_W'(DIGIT_COUNT - 1) - yoff[IDX_W-1:0];
  assign xch  = xz_q ? xsar_pkg::CH_ZERO : (xsar_pkg::CH_ZERO + {4'b0, xd_q[xidx*4 +: 4]});
  assign ych  = yz_q ? xsar_pkg::CH_ZERO : (xsar_pkg::CH_ZERO + {4'b0, yd_q[yidx*4 +: 4]});

  // a zero value prints one digit and jumps past the rest of the field
  always_comb begin
    priority if (xz_q && pos_q == POS_W'(P_XNUM)) begin
      pos_d = POS_W'(P_XSP);
    end else if (yz_q && pos_q == POS_W'(P_YNUM)) begin
      pos_d = POS_W'(P_NL);
    end else begin
      pos_d = pos_q + POS_W'(1);
    end
  end

  always_comb begin
    priority if (pos_q == POS_W'(0)) begin
      text_byte_o = xsar_pkg::CH_X;
    end else if (pos_q == POS_W'(1)) begin
      text_byte_o = xsar_pkg::CH_COLON;
    end else if (pos_q == POS_W'(2)) begin
      text_byte_o = xsar_pkg::CH_SPACE;
    end else if (pos_q == POS_W'(3)) begin
      text_byte_o = xsar_pkg::CH_PLUS;
    end else if (pos_q < POS_W'(P_XSP)) begin
      text_byte_o = xch;
    end else if (pos_q == POS_W'(P_XSP)) begin
      text_byte_o = xsar_pkg::CH_SPACE;
    end else if (pos_q == POS_W'(P_Y)) begin
      text_byte_o = xsar_pkg::CH_Y;
    end else if (pos_q == POS_W'(P_YC)) begin
      text_byte_o = xsar_pkg::CH_COLON;
    end else if (pos_q == POS_W'(P_YSP)) begin
      text_byte_o = xsar_pkg::CH_SPACE;
    end else if (pos_q == POS_W'(P_YPLUS)) begin
      text_byte_o = xsar_pkg::CH_PLUS;
    end else if (pos_q < POS_W'(P_NL)) begin
      text_byte_o = ych;
    end else begin
      text_byte_o = xsar_pkg::CH_NL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      pos_q <= '0;
    end else begin
      if (load) begin
        v_q   <= 1'b1;
        pos_q <= '0;
      end else if (v_q) begin
        if (last) begin
          v_q <= 1'b0;
        end else begin
          pos_q <= pos_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      xd_q <= x_digits_i;
      yd_q <= y_digits_i;
      xz_q <= x_zero_i;
      yz_q <= y_zero_i;
    end
  end

  assign text_valid_o = v_q;
  assign line_end_o   = v_q && last;

endmodule

`default_nettype wire

[rtl/xy_sample_ascii_reporter.sv]
// ----------------------------------------------------------------------------
// xy_sample_ascii_reporter
// Formats a touch coordinate pair as an ASCII report line, one byte a cycle.
// ----------------------------------------------------------------------------
//
//   channel   signals                            transfer
//   input     start_i, busy_o, x/y_sample_i      start_i high while busy_o low
//   result    text_valid_o, text_byte_o,         every cycle text_valid_o is
//             line_end_o                         high, no back-pressure
//   config    cfg_we_i, cfg_wdata_i              any edge with cfg_we_i high
//
// the first byte of a report reaches the result ports once its pair has passed
// the capture, hundreds split and digit split stages and been loaded into the
// line serialiser; a line is 20 bytes, 16 with one zero coordinate and 12
// with both, sent one byte a cycle, so the serialiser sets the sustained rate
// of pairs; it takes the next pair's digits only when idle or on a newline.
// a rejected pair is taken and sends nothing.
// three pairs can wait in the pipeline behind the line being sent; busy_o
// rises only when all stages are full. reset clears all valid bits and sets
// the limit to 900.
// ----------------------------------------------------------------------------
`default_nettype none

module xy_sample_ascii_reporter #(
  parameter int unsigned DIGIT_COUNT = xsar_pkg::DIGIT_COUNT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [xsar_pkg::SAMPLE_W-1:0] x_sample_i,
  input  wire logic [xsar_pkg::SAMPLE_W-1:0] y_sample_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [xsar_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  output logic                               text_valid_o,
  output logic [7:0]                         text_byte_o,
  output logic                               line_end_o
);

  xsar_pkg::sample_pair_t   in_pair;
  xsar_pkg::sample_pair_t   s1_pair;
  logic                     s1_valid;
  logic                     bcd_ready;
  logic                     bcd_valid;
  logic                     ser_ready;
  logic [DIGIT_COUNT*4-1:0] x_digits;
  logic [DIGIT_COUNT*4-1:0] y_digits;
  logic                     x_zero;
  logic                     y_zero;

  assign in_pair.x = x_sample_i;
  assign in_pair.y = y_sample_i;

  xsar_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .sample_i    (in_pair),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (s1_valid),
    .out_pair_o  (s1_pair),
    .out_ready_i (bcd_ready)
  );

  xsar_bcd #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_bcd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid),
    .in_ready_o  (bcd_ready),
    .in_pair_i   (s1_pair),
    .out_valid_o (bcd_valid),
    .out_ready_i (ser_ready),
    .x_digits_o  (x_digits),
    .y_digits_o  (y_digits),
    .x_zero_o    (x_zero),
    .y_zero_o    (y_zero)
  );

  xsar_serial #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (bcd_valid),
    .in_ready_o   (ser_ready),
    .x_digits_i   (x_digits),
    .y_digits_i   (y_digits),
    .x_zero_i     (x_zero),
    .y_zero_i     (y_zero),
    .text_valid_o (text_valid_o),
    .text_byte_o  (text_byte_o),
    .line_end_o   (line_end_o)
  );

endmodule

`default_nettype wire

[dv/tb_xy_sample_ascii_reporter.sv]
// ----------------------------------------------------------------------------
// tb_xy_sample_ascii_reporter
// Self-checking bench for the touch coordinate ASCII reporter. A stimulus
// table covers the extremes of both coordinates and of the acceptance limit,
// then random pairs are sent in phases under several limits. Each pair's
// report line is worked out in the bench and every byte on the text channel
// is compared with it in order.
// ----------------------------------------------------------------------------

module tb_xy_sample_ascii_reporter;

  localparam int SAMPLE_W        = xsar_pkg::SAMPLE_W;
  localparam int LIMIT_W         = xsar_pkg::LIMIT_W;
  localparam int DIR_N           = 24;
  localparam int SETTLE_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int PHASE_N         = 7;

  typedef enum int {ROW_LINE, ROW_NONE, ROW_MODEL} row_kind_e;

  typedef struct {
    logic [LIMIT_W-1:0]  limit;
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] y;
    row_kind_e           kind;
    string               text;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [SAMPLE_W-1:0] x_sample_i;
  logic [SAMPLE_W-1:0] y_sample_i;
  logic                cfg_we_i;
  logic [LIMIT_W-1:0]  cfg_wdata_i;
  logic                text_valid_o;
  logic [7:0]          text_byte_o;
  logic                line_end_o;

  text_beat_t          report_bytes_q[$];
  text_beat_t          next_beat;
  logic [LIMIT_W-1:0]  limit_model;
  int                  gap_max;
  int                  mismatch_count;
  int                  pairs_sent;
  int                  lines_seen;
  int                  bytes_checked;
  int                  limit_writes;
  int                  idle_cycles;

  dir_row_t dir_rows [DIR_N] = '{
    '{900,    0,    0, ROW_LINE,  "X: +0 Y: +0\n"},
    '{900,  899,  899, ROW_LINE,  "X: +00899 Y: +00899\n"},
    '{900,  900,    0, ROW_NONE,  ""},
    '{900,    0,  900, ROW_NONE,  ""},
    '{900,    1,   10, ROW_LINE,  "X: +00001 Y: +00010\n"},
    '{900,  123,  456, ROW_MODEL, ""},
    '{900,    0,  512, ROW_MODEL, ""},
    '{900,  899,    0, ROW_MODEL, ""},
    '{900, 1023, 1023, ROW_NONE,  ""},
    '{1024, 1023, 1023, ROW_LINE, "X: +01023 Y: +01023\n"},
    '{1024, 1023,    0, ROW_LINE, "X: +01023 Y: +0\n"},
    '{1024,  682,  341, ROW_MODEL, ""},
    '{1024,  341,  682, ROW_MODEL, ""},
    '{1024,  999,   10, ROW_MODEL, ""},
    '{0,      0,    0, ROW_NONE,  ""},
    '{0,   1023, 1023, ROW_NONE,  ""},
    '{1,      0,    0, ROW_LINE,  "X: +0 Y: +0\n"},
    '{1,      1,    0, ROW_NONE,  ""},
    '{1,      0,    1, ROW_NONE,  ""},
    '{1023, 1022, 1022, ROW_MODEL, ""},
    '{1023, 1023,    5, ROW_NONE,  ""},
    '{512,  511,  511, ROW_MODEL, ""},
    '{512,  512,  100, ROW_NONE,  ""},
    '{512,  256,  128, ROW_MODEL, ""}
  };

  xy_sample_ascii_reporter #(
    .DIGIT_COUNT (xsar_pkg::DIGIT_COUNT_DEF)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .x_sample_i   (x_sample_i),
    .y_sample_i   (y_sample_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .text_valid_o (text_valid_o),
    .text_byte_o  (text_byte_o),
    .line_end_o   (line_end_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  task automatic flag_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic push_text_byte(input logic [7:0] ch, input logic last);
    report_bytes_q.push_back('{ch: ch, last: last});
  endtask

  // sign then either a bare zero or the zero-padded decimal digits
  task automatic queue_number_text(input logic [SAMPLE_W-1:0] value);
    int v;
    int k;
    v = value;
    push_text_byte(xsar_pkg::CH_PLUS, 1'b0);
    if (v == 0) begin
      push_text_byte(xsar_pkg::CH_ZERO, 1'b0);
    end else begin
      for (k = xsar_pkg::DIGIT_COUNT_DEF - 1; k >= 0; k--) begin
        push_text_byte(xsar_pkg::CH_ZERO + 8'((v / (10 ** k)) % 10), 1'b0);
      end
    end
  endtask

  task automatic queue_report_line(input logic [SAMPLE_W-1:0] x,
                                   input logic [SAMPLE_W-1:0] y);
    if ({1'b0, x} < limit_model && {1'b0, y} < limit_model) begin
      push_text_byte(xsar_pkg::CH_X, 1'b0);
      push_text_byte(xsar_pkg::CH_COLON, 1'b0);
      push_text_byte(xsar_pkg::CH_SPACE, 1'b0);
      queue_number_text(x);
      push_text_byte(xsar_pkg::CH_SPACE, 1'b0);
      push_text_byte(xsar_pkg::CH_Y, 1'b0);
      push_text_byte(xsar_pkg::CH_COLON, 1'b0);
      push_text_byte(xsar_pkg::CH_SPACE, 1'b0);
      queue_number_text(y);
      push_text_byte(xsar_pkg::CH_NL, 1'b1);
    end
  endtask

  // returns at the edge where the pair is taken
  task automatic send_pair(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y);
    int gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    x_sample_i <= x;
    y_sample_i <= y;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pairs_sent++;
  endtask

  // waits on past an empty queue so that a stray byte after the last line is still caught
  task automatic drain_reports();
    start_i <= 1'b0;
    while (report_bytes_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_model = value;
    limit_writes++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [LIMIT_W-1:0] limit);
    int r;
    int top;
    r   = $urandom_range(0, 15);
    top = (limit > 1024) ? 1024 : int'(limit);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return SAMPLE_W'((top == 0) ? 0 : top - 1);
    if (r == 3) return SAMPLE_W'((top > 1023) ? 1023 : top);
    if (r <= 12 && top > 0) return SAMPLE_W'($urandom_range(0, top - 1));
    return SAMPLE_W'($urandom_range(0, 1023));
  endfunction

  // result channel: every strobed byte is a transfer
  always @(posedge clk_i) begin
    if (rst_ni && text_valid_o === 1'b1) begin
      if (report_bytes_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected byte 8'h%02h line_end %b",
                                text_byte_o, line_end_o));
      end else begin
        next_beat = report_bytes_q.pop_front();
        bytes_checked++;
        if (text_byte_o !== next_beat.ch)
          flag_mismatch($sformatf("text_byte 8'h%02h, expected 8'h%02h",
                                  text_byte_o, next_beat.ch));
        if (line_end_o !== next_beat.last)
          flag_mismatch($sformatf("line_end %b, expected %b on byte 8'h%02h",
                                  line_end_o, next_beat.last, next_beat.ch));
        if (next_beat.last) lines_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && busy_o === 1'b0) || text_valid_o === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles with no transfer", idle_cycles);
      $display("[xy_sample_ascii_reporter] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [LIMIT_W-1:0] phase_limit [PHASE_N];
    int                 phase_items [PHASE_N];
    int                 p;
    int                 i;
    int                 c;

    rst_ni         = 1'b0;
    start_i        = 1'b0;
    x_sample_i     = '0;
    y_sample_i     = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    idle_cycles    = 0;
    mismatch_count = 0;
    pairs_sent     = 0;
    lines_seen     = 0;
    bytes_checked  = 0;
    limit_writes   = 0;
    limit_model    = xsar_pkg::LIMIT_RESET;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table, first rows run under the limit left by reset
    gap_max = 12;
    for (i = 0; i < DIR_N; i++) begin
      if (dir_rows[i].limit != limit_model) begin
        drain_reports();
        write_limit(dir_rows[i].limit);
      end
      send_pair(dir_rows[i].x, dir_rows[i].y);
      case (dir_rows[i].kind)
        ROW_LINE: begin
          for (c = 0; c < dir_rows[i].text.len(); c++)
            push_text_byte(dir_rows[i].text[c], c == dir_rows[i].text.len() - 1);
        end
        ROW_MODEL: queue_report_line(dir_rows[i].x, dir_rows[i].y);
        default: ;
      endcase
    end

    // random phases; a zero limit rejects everything so that phase stays short
    phase_limit = '{1024, xsar_pkg::LIMIT_RESET, LIMIT_W'($urandom_range(1, 1024)), 1, 0,
                    LIMIT_W'($urandom_range(1, 1024)), 1024};
    phase_items = '{60, 60, 50, 20, 10, 50, 60};
    for (p = 0; p < PHASE_N; p++) begin
      drain_reports();
      write_limit(phase_limit[p]);
      case (p % 3)
        0: gap_max = 12;
        1: gap_max = 0;
        default: gap_max = 3;
      endcase
      for (i = 0; i < phase_items[p]; i++) begin
        // let the pipeline run dry once in the middle of a phase
        if (p == 0 && i == 30) drain_reports();
        send_pair(pick_sample(limit_model), pick_sample(limit_model));
        queue_report_line(x_sample_i, y_sample_i);
      end
    end

    drain_reports();
    $display("sent %0d pairs under %0d limit writes, %0d lines and %0d bytes checked",
             pairs_sent, limit_writes, lines_seen, bytes_checked);
    if (mismatch_count == 0) begin
      $display("[xy_sample_ascii_reporter] OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("[xy_sample_ascii_reporter] ERROR");
    end
    $finish;
  end

endmodule
